/* rtl/core/jds_pkg.sv */
package jds_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int DZ_W       = 11;
    localparam int AXIS_W     = 8;
    localparam int PCT_W      = 7;
    localparam int LED_W      = 3;
    localparam int SPD_W      = 2;
    localparam int NUM_AXES   = 4;
    localparam int AXIS_IDX_W = 2;

    // shared divider: dividend covers the scaled deviation and the widest calibration sum
    localparam int DVD_W   = 20;
    localparam int DVS_W   = 12;
    localparam int DCNT_W  = $clog2(DVD_W + 1);

    localparam int SPAN_W  = SAMPLE_W + 2;
    localparam int NUM_W   = 19;

    localparam logic [SAMPLE_W-1:0] FULL_SCALE   = 12'd4095;
    localparam logic [SAMPLE_W-1:0] CENTER_RESET = 12'd2048;
    localparam logic [6:0]          SCALE        = 7'd100;
    localparam logic [DZ_W-1:0]     DZ_MOVE_RESET = 11'd200;
    localparam logic [DZ_W-1:0]     DZ_PAN_RESET  = 11'd350;

    localparam logic REG_DZ_MOVE = 1'b0;
    localparam logic REG_DZ_PAN  = 1'b1;

    localparam logic CMD_POLL = 1'b0;
    localparam logic CMD_CAL  = 1'b1;

    localparam logic [SPD_W-1:0] SPD_SLOW = 2'd0;
    localparam logic [SPD_W-1:0] SPD_MID  = 2'd1;
    localparam logic [SPD_W-1:0] SPD_FAST = 2'd2;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DVD_W-1:0] quotient;
    } t_div_rsp;

    function automatic logic [PCT_W-1:0] speed_pct(input logic [SPD_W-1:0] idx);
        logic [PCT_W-1:0] p;
        case (idx)
            SPD_SLOW: p = 7'd30;
            SPD_MID:  p = 7'd60;
            SPD_FAST: p = 7'd100;
            default:  p = 7'd30;
        endcase
        return p;
    endfunction

    function automatic logic [LED_W-1:0] speed_led(input logic [SPD_W-1:0] idx);
        logic [LED_W-1:0] l;
        case (idx)
            SPD_SLOW: l = 3'b001;
            SPD_MID:  l = 3'b010;
            SPD_FAST: l = 3'b100;
            default:  l = 3'b001;
        endcase
        return l;
    endfunction

endpackage

/* rtl/core/jds_div.sv */
module jds_div
    import jds_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [DVD_W-1:0]  r_quo,  n_quo;
    logic [DVS_W:0]    r_rem,  n_rem;
    logic [DVS_W-1:0]  r_dvs;
    logic [DCNT_W-1:0] r_cnt,  n_cnt;
    logic              r_busy, n_busy;
    logic              r_done, n_done;

    logic [DVS_W:0] w_shift;
    logic [DVS_W:0] w_diff;
    logic           w_fit;

    // restoring step: one quotient bit per cycle
    assign w_shift = {r_rem[DVS_W-1:0], r_quo[DVD_W-1]};
    assign w_fit   = (w_shift >= {1'b0, r_dvs});
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_quo  = i_req.dividend;
            n_rem  = '0;
            n_cnt  = DCNT_W'(DVD_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = w_fit ? w_diff : w_shift;
            n_quo = {r_quo[DVD_W-2:0], w_fit};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == DCNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_req.start) begin
            r_dvs <= i_req.divisor;
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

`ifndef SYNTHESIS
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider started while busy");
    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < {1'b0, r_dvs}))
        else $error("partial remainder not below divisor");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("done without a running division");
`endif

endmodule

/* rtl/core/jds_speed.sv */
module jds_speed
    import jds_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic             i_button,
    output logic [PCT_W-1:0] o_pct,
    output logic [LED_W-1:0] o_leds
);

    logic [SPD_W-1:0] r_idx, n_idx;
    logic             r_prev_btn;
    logic             w_fall;

    assign w_fall = r_prev_btn & ~i_button;

    always_comb begin
        n_idx = r_idx;
        if (i_step && w_fall) begin
            case (r_idx)
                SPD_SLOW: n_idx = SPD_MID;
                SPD_MID:  n_idx = SPD_FAST;
                default:  n_idx = SPD_SLOW;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= SPD_SLOW;
            r_prev_btn <= 1'b1;
        end else if (i_step) begin
            r_idx      <= n_idx;
            r_prev_btn <= i_button;
        end
    end

    assign o_pct  = speed_pct(r_idx);
    assign o_leds = speed_led(r_idx);

`ifndef SYNTHESIS
    a_leds_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(o_leds))
        else $error("speed LEDs not one-hot");
    a_step_on_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_prev_btn && !i_button) |=> (r_idx != $past(r_idx)))
        else $error("button press did not step the speed");
    a_hold_no_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_idx))
        else $error("speed changed without a transfer");
`endif

endmodule

/* rtl/core/joystick_deadzone_scaler.sv */
// Joystick deadzone scaler. Each input transfer carries four 12-bit stick samples and the
// speed button level; tuser selects a poll item (0) or a calibration item (1). Every item
// gives exactly one output transfer. A poll item runs each axis outside the deadzone and with
// a positive span through one shared restoring divider in turn: a divided axis has a setup step,
// the 20 quotient bits and a step to take the quotient, and an axis that needs no division has
// only the setup step. A calibration item adds its samples to the four running sums, except
// the CAL_SAMPLES-th, which after adding its samples divides the four sums through the same
// divider into new centers and clears the sums. s_axis_tready is high only while no item is
// in work; a finished result waits in the output register and does not block the next input,
// but the item after it holds in its last cycle until that register is free. Deadzones are
// written over the cfg port (index 0 movement, 1 pan) by the user, who must do so only while
// idle; the block itself does not enforce this.
module joystick_deadzone_scaler
    import jds_pkg::*;
#(
    parameter int CAL_SAMPLES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // cfg port
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [10:0] i_cfg_wdata,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: move_x_raw[11:0], move_y_raw[23:12], pan_x_raw[35:24], pan_y_raw[47:36],
    //        button_level[48], zero pad[55:49]
    input  logic [55:0] s_axis_tdata,
    // tuser: cmd[0]
    input  logic        s_axis_tuser,
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: move_x[7:0], move_y[15:8], pan_x[23:16], pan_y[31:24], speed_percent[38:32],
    //        speed_leds[41:39], calibration_done[42], zero pad[47:43]
    output logic [47:0] m_axis_tdata
);

    localparam int CNT_W = $clog2(CAL_SAMPLES + 1);
    localparam int SUM_W = SAMPLE_W + $clog2(CAL_SAMPLES);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PREP = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]            r_state, n_state;
    logic [AXIS_IDX_W-1:0] r_axis;
    logic                  r_cal;
    logic                  r_done_flag;
    logic                  r_sign;
    logic [DZ_W-1:0]       r_dz_move, r_dz_pan;
    logic [CNT_W-1:0]      r_count;
    logic [SAMPLE_W-1:0]   r_raw    [NUM_AXES];
    logic [SAMPLE_W-1:0]   r_center [NUM_AXES];
    logic [SUM_W-1:0]      r_sum    [NUM_AXES];
    logic [AXIS_W-1:0]     r_val    [NUM_AXES];
    logic                  r_out_valid;
    logic [47:0]           r_out_data;

    logic                  w_accept;
    logic                  w_last_cal;
    logic [SAMPLE_W-1:0]   w_raw, w_cen;
    logic [DZ_W-1:0]       w_dz;
    logic signed [SAMPLE_W:0] w_delta, w_neg;
    logic                  w_pos;
    logic [SAMPLE_W-1:0]   w_mag, w_dev;
    logic                  w_inside;
    logic signed [SPAN_W-1:0] w_span_p, w_span_n, w_span;
    logic                  w_span_ok;
    logic [NUM_W-1:0]      w_num;
    logic                  w_skip;
    logic [6:0]            w_qclamp;
    logic [AXIS_W-1:0]     w_qval;
    logic [PCT_W-1:0]      w_pct;
    logic [LED_W-1:0]      w_leds;

    t_div_req w_req;
    t_div_rsp w_rsp;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid & s_axis_tready;
    assign w_last_cal    = (r_count == CNT_W'(CAL_SAMPLES - 1));

    // per-axis deviation, deadzone test and span for the current axis
    assign w_raw    = r_raw[r_axis];
    assign w_cen    = r_center[r_axis];
    assign w_dz     = r_axis[1] ? r_dz_pan : r_dz_move;
    assign w_delta  = $signed({1'b0, w_raw}) - $signed({1'b0, w_cen});
    assign w_neg    = -w_delta;
    assign w_pos    = (w_delta > 0);
    assign w_mag    = w_pos ? w_delta[SAMPLE_W-1:0] : w_neg[SAMPLE_W-1:0];
    assign w_inside = (w_mag < {1'b0, w_dz});
    assign w_span_p = $signed({2'b00, FULL_SCALE}) - $signed({2'b00, w_cen})
                    - $signed({3'b000, w_dz});
    assign w_span_n = $signed({2'b00, w_cen}) - $signed({3'b000, w_dz});
    assign w_span   = w_pos ? w_span_p : w_span_n;
    assign w_span_ok = (w_span > 0);
    assign w_dev    = w_mag - {1'b0, w_dz};
    assign w_num    = NUM_W'(w_dev) * NUM_W'(SCALE);
    assign w_skip   = w_inside | ~w_span_ok;

    assign w_qclamp = (w_rsp.quotient > DVD_W'(SCALE)) ? SCALE : w_rsp.quotient[6:0];
    assign w_qval   = r_sign ? (AXIS_W'(0) - {1'b0, w_qclamp}) : {1'b0, w_qclamp};

    always_comb begin
        w_req = '0;
        if (r_state == S_PREP) begin
            if (r_cal) begin
                w_req.start    = 1'b1;
                w_req.dividend = DVD_W'(r_sum[r_axis]);
                w_req.divisor  = DVS_W'(CAL_SAMPLES);
            end else begin
                w_req.start    = ~w_skip;
                w_req.dividend = DVD_W'(w_num);
                w_req.divisor  = w_span[DVS_W-1:0];
            end
        end
    end

    jds_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    jds_speed u_speed (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_accept),
        .i_button (s_axis_tdata[48]),
        .o_pct    (w_pct),
        .o_leds   (w_leds)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (s_axis_tuser == CMD_CAL) begin
                        n_state = w_last_cal ? S_PREP : S_FIN;
                    end else begin
                        n_state = S_PREP;
                    end
                end
            end
            S_PREP: begin
                if (!r_cal && w_skip) begin
                    n_state = (r_axis == AXIS_IDX_W'(NUM_AXES - 1)) ? S_FIN : S_PREP;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_rsp.done) begin
                    n_state = (r_axis == AXIS_IDX_W'(NUM_AXES - 1)) ? S_FIN : S_PREP;
                end
            end
            S_FIN: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= '0;
            r_cal       <= 1'b0;
            r_done_flag <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_dz_move   <= DZ_MOVE_RESET;
            r_dz_pan    <= DZ_PAN_RESET;
            for (int i = 0; i < NUM_AXES; i++) begin
                r_center[i] <= CENTER_RESET;
                r_sum[i]    <= '0;
            end
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_DZ_MOVE: r_dz_move <= i_cfg_wdata;
                    REG_DZ_PAN:  r_dz_pan  <= i_cfg_wdata;
                    default:     ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_axis      <= '0;
                        r_cal       <= s_axis_tuser;
                        r_done_flag <= (s_axis_tuser == CMD_CAL) && w_last_cal;
                        if (s_axis_tuser == CMD_CAL) begin
                            for (int i = 0; i < NUM_AXES; i++) begin
                                r_sum[i] <= r_sum[i]
                                          + SUM_W'(s_axis_tdata[i*SAMPLE_W +: SAMPLE_W]);
                            end
                            r_count     <= w_last_cal ? '0 : r_count + 1'b1;
                        end
                    end
                end
                S_PREP: begin
                    if (!r_cal && w_skip) begin
                        r_axis <= r_axis + 1'b1;
                    end
                end
                S_DIV: begin
                    if (w_rsp.done) begin
                        if (r_cal) begin
                            r_center[r_axis] <= w_rsp.quotient[SAMPLE_W-1:0];
                            r_sum[r_axis]    <= '0;
                        end
                        r_axis <= r_axis + 1'b1;
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                    end
                end
                default: ;
            endcase

            if (r_state != S_FIN && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && w_accept) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                r_raw[i] <= s_axis_tdata[i*SAMPLE_W +: SAMPLE_W];
                r_val[i] <= '0;
            end
        end
        if (r_state == S_PREP) begin
            r_sign <= ~w_pos;
            if (!r_cal && w_skip) begin
                r_val[r_axis] <= '0;
            end
        end
        if (r_state == S_DIV && w_rsp.done && !r_cal) begin
            r_val[r_axis] <= w_qval;
        end
        if (r_state == S_FIN && (!r_out_valid || m_axis_tready)) begin
            r_out_data <= {5'd0, r_done_flag, w_leds, w_pct,
                           r_val[3], r_val[2], r_val[1], r_val[0]};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !s_axis_tready)
        else $error("ready again right after a transfer");
    a_div_only_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.busy |-> (r_state == S_DIV))
        else $error("divider running outside the divide state");
    a_cal_zero_axes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) && r_out_data[42] |-> (r_out_data[31:0] == 32'd0))
        else $error("calibration result with nonzero axes");
    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && w_rsp.done && !r_cal) |=>
        ($signed(r_val[$past(r_axis)]) <= 8'sd100 &&
         $signed(r_val[$past(r_axis)]) >= -8'sd100))
        else $error("axis result out of range");
`endif

endmodule

/* tb/joystick_deadzone_scaler_tb.sv */
`timescale 1ns / 1ps

module joystick_deadzone_scaler_tb;
    import jds_pkg::*;

    localparam int CAL_SAMPLES = 64;
    localparam int LONG_HOLD   = 600;
    localparam int PHASE_ITEMS = 172;

    typedef struct packed {
        logic                          cmd;
        logic                          btn;
        logic [NUM_AXES-1:0][SAMPLE_W-1:0] raw;
    } t_stick_item;

    // same bit order as the output tdata, lowest field last
    typedef struct packed {
        logic                          cal_done;
        logic [LED_W-1:0]              leds;
        logic [PCT_W-1:0]              pct;
        logic [NUM_AXES-1:0][AXIS_W-1:0] axes;
    } t_stick_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_addr = REG_DZ_MOVE;
    logic [10:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic        s_axis_tuser = CMD_POLL;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;

    joystick_deadzone_scaler #(
        .CAL_SAMPLES(CAL_SAMPLES)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state
    int dz_move = DZ_MOVE_RESET;
    int dz_pan  = DZ_PAN_RESET;
    int axis_center [NUM_AXES] = '{default: CENTER_RESET};
    int cal_sum [NUM_AXES] = '{default: 0};
    int cal_count = 0;
    int speed_idx = SPD_SLOW;
    logic prev_btn = 1'b1;
    int pct_by_speed [3] = '{30, 60, 100};

    t_stick_item   sample_queue [$];
    t_stick_result pending_outputs [$];

    // run statistics
    int n_poll = 0;
    int n_cal = 0;
    int n_latched = 0;
    int n_presses = 0;
    int n_settings = 0;
    int long_holds = 0;
    int outputs_seen = 0;
    int mismatches = 0;

    // stimulus generator state
    logic gen_btn = 1'b1;
    int   gen_guess [NUM_AXES] = '{default: CENTER_RESET};

    t_stick_item in_flight;
    int   send_wait = 0;
    logic send_steady = 1'b0;
    int   recv_wait = 0;
    logic recv_steady = 1'b0;

    function automatic int scale_deviation(input int raw, input int ctr, input int dz);
        int dev;
        int span;
        int v;
        dev = raw - ctr;
        if (dev > -dz && dev < dz)
            return 0;
        span = (dev > 0) ? int'(FULL_SCALE) - ctr - dz : ctr - dz;
        if (span <= 0)
            return 0;
        if (dev > 0)
            v = ((dev - dz) * 100) / span;
        else
            v = ((dev + dz) * 100) / span;
        if (v > 100)
            v = 100;
        if (v < -100)
            v = -100;
        return v;
    endfunction

    task automatic predict_outputs(input t_stick_item it);
        t_stick_result r;
        int a;
        r = '0;
        if (it.cmd == CMD_CAL) begin
            n_cal++;
            for (a = 0; a < NUM_AXES; a++)
                cal_sum[a] += it.raw[a];
            cal_count++;
            if (cal_count >= CAL_SAMPLES) begin
                for (a = 0; a < NUM_AXES; a++) begin
                    axis_center[a] = cal_sum[a] / CAL_SAMPLES;
                    cal_sum[a] = 0;
                end
                cal_count = 0;
                r.cal_done = 1'b1;
                n_latched++;
            end
        end else begin
            n_poll++;
            for (a = 0; a < NUM_AXES; a++)
                r.axes[a] = AXIS_W'(scale_deviation(it.raw[a], axis_center[a],
                                                    (a < 2) ? dz_move : dz_pan));
        end
        // falling edge of the button steps the speed, on any item kind
        if (!it.btn && prev_btn) begin
            speed_idx = (speed_idx + 1) % 3;
            n_presses++;
        end
        prev_btn = it.btn;
        r.pct  = PCT_W'(pct_by_speed[speed_idx]);
        r.leds = 3'b001 << speed_idx;
        pending_outputs.push_back(r);
    endtask

    task automatic check_field(input string what, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    task automatic check_output(input t_stick_result got);
        t_stick_result want;
        int a;
        if (pending_outputs.size() == 0) begin
            mismatches++;
            $display("%0t ns: output transfer with nothing expected, actual %h",
                     $time, m_axis_tdata);
        end else begin
            want = pending_outputs.pop_front();
            for (a = 0; a < NUM_AXES; a++)
                check_field($sformatf("axis %0d", a), $signed(want.axes[a]),
                            $signed(got.axes[a]));
            check_field("speed_percent", want.pct, got.pct);
            check_field("speed_leds", want.leds, got.leds);
            check_field("calibration_done", want.cal_done, got.cal_done);
        end
    endtask

    // input side: present queued items, predict on each accepted transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_wait = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_outputs(in_flight);
                if ($urandom_range(0, 49) == 0)
                    send_steady = !send_steady;
                send_wait = send_steady ? 0 : $urandom_range(0, 15);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_wait == 0 && sample_queue.size() != 0) begin
                    in_flight = sample_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {7'd0, in_flight.btn, in_flight.raw};
                    s_axis_tuser  <= in_flight.cmd;
                end else begin
                    if (send_wait > 0)
                        send_wait--;
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // output side: random back-pressure, with a long hold now and then to fill the block
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_wait = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                check_output(t_stick_result'(m_axis_tdata[42:0]));
                outputs_seen++;
                if ($urandom_range(0, 49) == 0)
                    recv_steady = !recv_steady;
                recv_wait = recv_steady ? 0 : $urandom_range(0, 15);
                if (outputs_seen % 300 == 100) begin
                    recv_wait = LONG_HOLD;
                    long_holds++;
                end
            end
            if (recv_wait > 0) begin
                recv_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic int clamp_sample(input int v);
        if (v < 0)
            return 0;
        if (v > int'(FULL_SCALE))
            return int'(FULL_SCALE);
        return v;
    endfunction

    function automatic logic next_button();
        if ($urandom_range(0, 3) == 0)
            gen_btn = !gen_btn;
        return gen_btn;
    endfunction

    function automatic int pick_center();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 4095);
            1: return $urandom_range(0, 150);
            2: return $urandom_range(3945, 4095);
            default: return 2048 + $urandom_range(0, 600) - 300;
        endcase
    endfunction

    function automatic int pick_poll_sample(input int c);
        case ($urandom_range(0, 5))
            0, 1: return $urandom_range(0, 4095);
            2: return $urandom_range(0, 1) ? 0 : 4095;
            3: return c;
            default: return clamp_sample(c + $urandom_range(0, 2400) - 1200);
        endcase
    endfunction

    function automatic t_stick_item make_item(input logic cmd, input int mx, input int my,
                                              input int px, input int py, input logic btn);
        t_stick_item it;
        it.cmd = cmd;
        it.btn = btn;
        it.raw[0] = SAMPLE_W'(mx);
        it.raw[1] = SAMPLE_W'(my);
        it.raw[2] = SAMPLE_W'(px);
        it.raw[3] = SAMPLE_W'(py);
        return it;
    endfunction

    task automatic queue_random_phase(input int n_items);
        t_stick_item it;
        int queued;
        int kind;
        int run_len;
        int a;
        int k;
        queued = 0;
        while (queued < n_items) begin
            kind = $urandom_range(0, 11);
            if (kind < 2) begin
                // full calibration run around fresh centers
                for (a = 0; a < NUM_AXES; a++)
                    gen_guess[a] = pick_center();
                run_len = CAL_SAMPLES;
                for (k = 0; k < run_len; k++) begin
                    for (a = 0; a < NUM_AXES; a++)
                        it.raw[a] = SAMPLE_W'(clamp_sample(gen_guess[a]
                                                           + $urandom_range(0, 80) - 40));
                    it.cmd = CMD_CAL;
                    it.btn = next_button();
                    sample_queue.push_back(it);
                end
            end else if (kind < 11) begin
                run_len = $urandom_range(8, 30);
                for (k = 0; k < run_len; k++) begin
                    for (a = 0; a < NUM_AXES; a++)
                        it.raw[a] = SAMPLE_W'(pick_poll_sample(gen_guess[a]));
                    it.cmd = CMD_POLL;
                    it.btn = next_button();
                    sample_queue.push_back(it);
                end
            end else begin
                // stray calibration items that break the run alignment
                run_len = $urandom_range(1, 5);
                for (k = 0; k < run_len; k++) begin
                    for (a = 0; a < NUM_AXES; a++)
                        it.raw[a] = SAMPLE_W'($urandom_range(0, 4095));
                    it.cmd = CMD_CAL;
                    it.btn = next_button();
                    sample_queue.push_back(it);
                end
            end
            queued += run_len;
        end
    endtask

    task automatic write_deadzones(input logic [10:0] mv, input logic [10:0] pn);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= REG_DZ_MOVE;
        i_cfg_wdata <= mv;
        @(posedge i_clk);
        i_cfg_addr  <= REG_DZ_PAN;
        i_cfg_wdata <= pn;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        dz_move = mv;
        dz_pan  = pn;
        n_settings++;
    endtask

    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (sample_queue.size() != 0 || s_axis_tvalid || pending_outputs.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        int ph;
        logic [10:0] mv;
        logic [10:0] pn;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero movement deadzone, widest pan deadzone: exact center, full scale and zero span
        write_deadzones(11'd0, 11'd2047);
        sample_queue.push_back(make_item(CMD_POLL, 2048, 2048, 2048, 2048, 1'b1));
        sample_queue.push_back(make_item(CMD_POLL, 0, 0, 0, 0, 1'b1));
        sample_queue.push_back(make_item(CMD_POLL, 4095, 4095, 4095, 4095, 1'b0));
        sample_queue.push_back(make_item(CMD_POLL, 2049, 2047, 1, 4094, 1'b0));
        sample_queue.push_back(make_item(CMD_POLL, 'hAAA, 'h555, 'hAAA, 'h555, 1'b1));
        sample_queue.push_back(make_item(CMD_CAL, 4095, 0, 4095, 0, 1'b0));
        sample_queue.push_back(make_item(CMD_CAL, 'h555, 'hAAA, 'h555, 'hAAA, 1'b1));
        sample_queue.push_back(make_item(CMD_CAL, 0, 4095, 0, 4095, 1'b0));
        sample_queue.push_back(make_item(CMD_POLL, 2048, 0, 4095, 2048, 1'b1));
        sample_queue.push_back(make_item(CMD_POLL, 3000, 1000, 2100, 1990, 1'b0));
        sample_queue.push_back(make_item(CMD_POLL, 2047, 2049, 2047, 2049, 1'b1));
        sample_queue.push_back(make_item(CMD_POLL, 1, 4094, 4094, 1, 1'b0));
        sample_queue.push_back(make_item(CMD_POLL, 4094, 1, 2048, 2048, 1'b1));
        wait_idle();

        for (ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin mv = DZ_MOVE_RESET; pn = DZ_PAN_RESET; end
                1: begin mv = 11'd2047; pn = 11'd2047; end
                2: begin mv = 11'd0; pn = 11'd0; end
                3: begin mv = 11'd2047; pn = 11'd0; end
                default: begin
                    mv = $urandom_range(0, 1) ? 11'($urandom_range(0, 600))
                                              : 11'($urandom_range(0, 2047));
                    pn = $urandom_range(0, 1) ? 11'($urandom_range(0, 600))
                                              : 11'($urandom_range(0, 2047));
                end
            endcase
            write_deadzones(mv, pn);
            queue_random_phase(PHASE_ITEMS);
            wait_idle();
        end

        repeat (100) @(posedge i_clk);
        $display("Run covered %0d poll and %0d calibration transfers over %0d deadzone settings",
                 n_poll, n_cal, n_settings);
        $display("with %0d center updates, %0d button presses and %0d long output stalls",
                 n_latched, n_presses, long_holds);
        if (mismatches == 0)
            $display("PASS joystick_deadzone_scaler");
        else
            $display("FAIL joystick_deadzone_scaler");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Timed out with %0d outputs still expected", pending_outputs.size());
        $display("FAIL joystick_deadzone_scaler");
        $finish;
    end

endmodule
